### design/mts_pkg.sv
// shared types and codes for the min tracking stack
// used by mts_ctrl, mts_datapath and min_tracking_stack
package mts_pkg;

  localparam int unsigned DefaultDepth = 64;

  localparam int unsigned DataW  = 32;
  localparam int unsigned KindW  = 2;
  localparam int unsigned StatW  = 2;
  localparam int unsigned DepthW = 7;

  typedef enum logic [KindW-1:0] {
    KIND_QUERY = 2'd0,
    KIND_PUSH  = 2'd1,
    KIND_POP   = 2'd2,
    KIND_RSVD  = 2'd3
  } kind_e;

  typedef enum logic [StatW-1:0] {
    STAT_OK        = 2'd0,
    STAT_POP_EMPTY = 2'd1,
    STAT_PUSH_FULL = 2'd2,
    STAT_RSVD      = 2'd3
  } stat_e;

  // controller to datapath
  typedef struct packed {
    logic  push;      // store the input word, old top goes to memory
    logic  pop;       // drop the top, fetch the entry below it
    logic  load_top;  // take the fetched entry as the new top
    logic  set_stat;  // capture stat for the result
    stat_e stat;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic empty;
    logic full;
  } flags_t;

endpackage

### design/mts_ctrl.sv
// controller for the min tracking stack: sequences accept, pop fetch and result
// depends on mts_pkg
module mts_ctrl
  import mts_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [KindW-1:0]  kind_i,
  input  flags_t            flags_i,
  output cmd_t              cmd_o,
  output logic              busy_o,
  output logic              done_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_LOAD = 2'd1;
  localparam logic [1:0] S_RESP = 2'd2;

  logic [1:0] state_q, state_d;
  logic       accept;

  assign accept = start_i && (state_q == S_IDLE);
  assign busy_o = (state_q != S_IDLE);
  assign done_o = (state_q == S_RESP);

  always_comb begin
    state_d = state_q;
    cmd_o   = '{push: 1'b0, pop: 1'b0, load_top: 1'b0, set_stat: 1'b0, stat: STAT_OK};
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          cmd_o.set_stat = 1'b1;
          state_d        = S_RESP;
          case (kind_i)
            KIND_PUSH: begin
              if (flags_i.full) begin
                cmd_o.stat = STAT_PUSH_FULL;
              end else begin
                cmd_o.push = 1'b1;
              end
            end
            KIND_POP: begin
              if (flags_i.empty) begin
                cmd_o.stat = STAT_POP_EMPTY;
              end else begin
                cmd_o.pop = 1'b1;
                state_d   = S_LOAD;
              end
            end
            default: begin
              // query, and the unused code acts as a query
            end
          endcase
        end
      end
      S_LOAD: begin
        cmd_o.load_top = 1'b1;
        state_d        = S_RESP;
      end
      S_RESP: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

### design/mts_datapath.sv
// datapath for the min tracking stack: top entry in registers, the rest in memory
// depends on mts_pkg
module mts_datapath
  import mts_pkg::*;
#(
  parameter int unsigned DEPTH = DefaultDepth
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic signed [DataW-1:0]  push_value_i,
  input  cmd_t                     cmd_i,
  output flags_t                   flags_o,
  output logic signed [DataW-1:0]  top_value_o,
  output logic signed [DataW-1:0]  min_value_o,
  output logic [DepthW-1:0]        depth_o,
  output logic                     is_empty_o,
  output logic                     is_full_o,
  output logic [StatW-1:0]         status_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  // each memory word holds a value and its running minimum
  logic [2*DataW-1:0] mem_q [DEPTH];
  logic [2*DataW-1:0] rd_q;

  logic [CW-1:0]            count_q, count_d;
  logic signed [DataW-1:0]  top_val_q, top_val_d;
  logic signed [DataW-1:0]  top_min_q, top_min_d;
  stat_e                    stat_q;

  logic [CW-1:0]            wr_ptr, rd_ptr;
  logic signed [DataW-1:0]  new_min;
  logic                     empty, full;

  assign empty = (count_q == '0);
  assign full  = (count_q == CW'(DEPTH));
  assign flags_o = '{empty: empty, full: full};

  // old top goes to the slot just below the new top
  assign wr_ptr = count_q - CW'(1);
  assign rd_ptr = count_q - CW'(2);

  always_comb begin
    new_min = push_value_i;
    if (!empty && (top_min_q < push_value_i)) begin
      new_min = top_min_q;
    end
  end

  always_comb begin
    count_d   = count_q;
    top_val_d = top_val_q;
    top_min_d = top_min_q;
    if (cmd_i.push) begin
      count_d   = count_q + CW'(1);
      top_val_d = push_value_i;
      top_min_d = new_min;
    end else if (cmd_i.pop) begin
      count_d = count_q - CW'(1);
    end else if (cmd_i.load_top) begin
      top_val_d = rd_q[2*DataW-1:DataW];
      top_min_d = rd_q[DataW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.push && !empty) begin
      mem_q[wr_ptr[AW-1:0]] <= {top_val_q, top_min_q};
    end
    rd_q <= mem_q[rd_ptr[AW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    top_val_q <= top_val_d;
    top_min_q <= top_min_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      stat_q  <= STAT_OK;
    end else begin
      count_q <= count_d;
      if (cmd_i.set_stat) begin
        stat_q <= cmd_i.stat;
      end
    end
  end

  assign top_value_o = empty ? '0 : top_val_q;
  assign min_value_o = empty ? '0 : top_min_q;
  assign depth_o     = DepthW'(count_q);
  assign is_empty_o  = empty;
  assign is_full_o   = full;
  assign status_o    = stat_q;

endmodule

### design/min_tracking_stack.sv
// top level of the min tracking stack: controller plus datapath
// depends on mts_pkg, mts_ctrl, mts_datapath
//
//   channel   strobe    hold-off   ports
//   command   start     busy       kind_i, push_value_i
//   result    done_o    none       top_value_o, min_value_o, depth_o,
//                                  is_empty_o, is_full_o, status_o
//
// a query or push gives its result word in the cycle after accept; a pop goes
// through S_LOAD, for the registered read port of the entry memory below the top
// the result word shows for one cycle with done_o, and the next word is taken
// the cycle after, so no new command is taken until the last result has shown;
// the receiver cannot stall the block
// reset clears the entry count and the state; memory contents are not cleared
module min_tracking_stack
  import mts_pkg::*;
#(
  parameter int unsigned DEPTH = DefaultDepth
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start,
  output logic                     busy,
  input  logic [KindW-1:0]         kind_i,
  input  logic signed [DataW-1:0]  push_value_i,
  output logic                     done_o,
  output logic signed [DataW-1:0]  top_value_o,
  output logic signed [DataW-1:0]  min_value_o,
  output logic [DepthW-1:0]        depth_o,
  output logic                     is_empty_o,
  output logic                     is_full_o,
  output logic [StatW-1:0]         status_o
);

  cmd_t   cmd;
  flags_t flags;

  mts_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .kind_i  (kind_i),
    .flags_i (flags),
    .cmd_o   (cmd),
    .busy_o  (busy),
    .done_o  (done_o)
  );

  mts_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_value_i (push_value_i),
    .cmd_i        (cmd),
    .flags_o      (flags),
    .top_value_o  (top_value_o),
    .min_value_o  (min_value_o),
    .depth_o      (depth_o),
    .is_empty_o   (is_empty_o),
    .is_full_o    (is_full_o),
    .status_o     (status_o)
  );

endmodule
